>>> sv/bfsp_pkg.sv
// Shared types and constants for the shortest-path solver.
package bfsp_pkg;
	localparam int VERT_BITS = 6;
	localparam int NUM_VERT = 64;
	localparam int EDGE_ABITS = 10;
	localparam int MAX_EDGES = 1024;
	localparam int WEIGHT_BITS = 16;
	localparam int DIST_BITS = 40;
	localparam int OUT_BITS = 23;
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SOLVE = 1'b1;
	localparam logic CFG_VCOUNT = 1'b0;
	localparam logic CFG_SOURCE = 1'b1;

	typedef logic [VERT_BITS-1:0] vert_t;
	typedef logic signed [DIST_BITS-1:0] dist_t;
	typedef struct packed {
		vert_t a;
		vert_t b;
		logic signed [WEIGHT_BITS-1:0] w;
	} edge_t;
endpackage

>>> sv/bfsp_edge_ram.sv
// Edge store: one write port, one registered read port.
module bfsp_edge_ram (
	input  logic                            clk,
	input  logic                            we,
	input  logic [bfsp_pkg::EDGE_ABITS-1:0] waddr,
	input  bfsp_pkg::edge_t                 wdata,
	input  logic [bfsp_pkg::EDGE_ABITS-1:0] raddr,
	output bfsp_pkg::edge_t                 rdata
);
	import bfsp_pkg::*;
	edge_t mem [MAX_EDGES];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> sv/bellman_ford_shortest_paths.sv
// Top level: single-source shortest paths solver over a stored edge list.
// Load words are accepted back to back while no result word waits and no solve runs.
// A solve walks the edge list once per pass plus one checking pass: fetch, read u, read v,
// relax in each direction, then advance; a skipped edge goes from reading u to the advance.
// Each result word is read, then emitted, and held while the receiver stalls.
// Reset clears control state, edge count and registers to 63 / 1; the memories are not cleared.
module bellman_ford_shortest_paths (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               opcode,
	input  logic [5:0]                         edge_from,
	input  logic [5:0]                         edge_to,
	input  logic signed [15:0]                 edge_weight,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [5:0]                         cfg_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [5:0]                         vertex_number,
	output logic signed [22:0]                 path_distance,
	output logic                               negative_cycle,
	output logic                               last_result
);
	import bfsp_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_FETCH = 8'b00000010,
		ST_RDU   = 8'b00000100,
		ST_RDV   = 8'b00001000,
		ST_RELAX = 8'b00010000,
		ST_NEXT  = 8'b00100000,
		ST_EMIT  = 8'b01000000,
		ST_WAIT  = 8'b10000000
	} state_t;

	state_t state_q;
	vert_t vcount_q, source_q, top_v, emit_v_q;
	logic [EDGE_ABITS:0] ecount_q;
	logic [EDGE_ABITS-1:0] eidx_q;
	logic [VERT_BITS-1:0] pass_q;
	logic changed_q, check_q, cycle_q, dir_q;
	logic [NUM_VERT-1:0] valid_q;
	edge_t edge_rd;
	dist_t dist_mem [NUM_VERT];
	dist_t drd_q, du_q;
	vert_t d_addr;
	logic d_we;
	dist_t d_wdata, cand;
	vert_t eu, ev;
	logic in_acc, out_acc, last_edge, solve_acc, emit_load;
	logic improve;

	assign top_v = (vcount_q == '0) ? vert_t'(1) : vcount_q;
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign solve_acc = in_acc && opcode == OP_SOLVE;
	// load the output register when it is empty or being drained this cycle
	assign emit_load = (state_q == ST_EMIT) && (!out_valid || out_acc);
	// hold input off while solving or while a result word waits
	assign in_stall = (state_q != ST_IDLE) || out_valid;

	bfsp_edge_ram u_ram (
		.clk(clk),
		.we(in_acc && opcode == OP_LOAD && ecount_q < (EDGE_ABITS+1)'(MAX_EDGES)),
		.waddr(ecount_q[EDGE_ABITS-1:0]),
		.wdata('{a: edge_from, b: edge_to, w: edge_weight}),
		.raddr(eidx_q),
		.rdata(edge_rd)
	);

	// direction: dir 0 relaxes a->b, dir 1 relaxes b->a
	assign eu = dir_q ? edge_rd.b : edge_rd.a;
	assign ev = dir_q ? edge_rd.a : edge_rd.b;
	assign cand = du_q + dist_t'(edge_rd.w);
	assign last_edge = ({1'b0, eidx_q} + 1'b1) >= ecount_q;

	assign improve = valid_q[eu] && (!valid_q[ev] || drd_q > cand);

	// One port on the distance memory: seed the source on a solve, read u, then read and
	// write v, and read each vertex in turn while the results go out.
	always_comb begin
		if (state_q == ST_IDLE) d_addr = source_q;
		else if (state_q == ST_RDU) d_addr = eu;
		else if (state_q == ST_WAIT || state_q == ST_EMIT) d_addr = emit_v_q;
		else d_addr = ev;
		d_we = solve_acc || ((state_q == ST_RELAX) && improve && !check_q);
		d_wdata = solve_acc ? '0 : cand;
	end

	always_ff @(posedge clk) begin
		if (d_we) dist_mem[d_addr] <= d_wdata;
		drd_q <= dist_mem[d_addr];
	end

	// Clamp a distance to the output range; unreachable vertices give -1.
	function automatic logic signed [OUT_BITS-1:0] sat_dist(input logic vld, input dist_t d);
		if (!vld) return '1;
		if (d > dist_t'(4194303)) return 23'sh3fffff;
		if (d < dist_t'(-4194304)) return 23'sh400000;
		return d[OUT_BITS-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vcount_q <= 6'd63;
			source_q <= 6'd1;
			ecount_q <= '0;
			eidx_q <= '0;
			pass_q <= '0;
			changed_q <= 1'b0;
			check_q <= 1'b0;
			cycle_q <= 1'b0;
			dir_q <= 1'b0;
			valid_q <= '0;
			du_q <= '0;
			out_valid <= 1'b0;
			emit_v_q <= '0;
			vertex_number <= '0;
			path_distance <= '0;
			negative_cycle <= 1'b0;
			last_result <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_VCOUNT) vcount_q <= cfg_data;
				else source_q <= cfg_data;
			end
			if (emit_load) out_valid <= 1'b1;
			else if (out_acc) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (opcode == OP_LOAD) begin
							if (ecount_q < (EDGE_ABITS+1)'(MAX_EDGES))
								ecount_q <= ecount_q + 1'b1;
						end else begin
							// seed the source: distance 0 goes into memory, mark it valid if it is not above the top vertex
							valid_q <= (source_q <= top_v) ? (NUM_VERT'(1) << source_q) : '0;
							eidx_q <= '0;
							pass_q <= '0;
							changed_q <= 1'b0;
							check_q <= 1'b0;
							cycle_q <= 1'b0;
							dir_q <= 1'b0;
							emit_v_q <= vert_t'(1);
							state_q <= (ecount_q == '0) ? ST_WAIT : ST_FETCH;
						end
					end
				end
				ST_FETCH: state_q <= ST_RDU; // edge word lands in edge_rd
				ST_RDU: begin
					if (edge_rd.a > top_v || edge_rd.b > top_v) state_q <= ST_NEXT;
					else state_q <= ST_RDV;
				end
				ST_RDV: begin
					du_q <= drd_q;
					state_q <= ST_RELAX;
				end
				ST_RELAX: begin
					if (improve) begin
						if (check_q) cycle_q <= 1'b1;
						else begin
							valid_q[ev] <= 1'b1;
							changed_q <= 1'b1;
						end
					end
					if (!dir_q) begin
						dir_q <= 1'b1;
						state_q <= ST_RDU;
					end else begin
						dir_q <= 1'b0;
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					dir_q <= 1'b0;
					if (!last_edge && !(check_q && cycle_q)) begin
						eidx_q <= eidx_q + 1'b1;
						state_q <= ST_FETCH;
					end else begin
						eidx_q <= '0;
						if (check_q) state_q <= ST_WAIT;
						else if (!changed_q || pass_q + 1'b1 >= top_v) begin
							check_q <= 1'b1;
							state_q <= ST_FETCH;
						end else begin
							pass_q <= pass_q + 1'b1;
							changed_q <= 1'b0;
							state_q <= ST_FETCH;
						end
					end
				end
				ST_WAIT: begin
					// drop the edge list; the distance of emit_v_q is being read
					ecount_q <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_load) begin
						if (cycle_q) begin
							vertex_number <= '0;
							path_distance <= '0;
							negative_cycle <= 1'b1;
							last_result <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							vertex_number <= emit_v_q;
							negative_cycle <= 1'b0;
							last_result <= (emit_v_q == top_v);
							path_distance <= sat_dist(valid_q[emit_v_q], drd_q);
							if (emit_v_q == top_v) state_q <= ST_IDLE;
							else begin
								emit_v_q <= emit_v_q + 1'b1;
								state_q <= ST_WAIT;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> tb/tb.sv
// Testbench for the Bellman-Ford shortest-path solver: directed table, then random graphs.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bfsp_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = OP_LOAD;
	logic [5:0] edge_from = '0;
	logic [5:0] edge_to = '0;
	logic signed [15:0] edge_weight = '0;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_VCOUNT;
	logic [5:0] cfg_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [5:0] vertex_number;
	logic signed [22:0] path_distance;
	logic negative_cycle;
	logic last_result;

	bellman_ford_shortest_paths i_dut (.*);

	always #6 clk = ~clk;

	typedef struct {
		logic [5:0] vnum;
		logic signed [22:0] pdist;
		logic ncyc;
		logic last;
	} dist_word_t;

	typedef struct {
		logic op;
		logic [5:0] a;
		logic [5:0] b;
		logic signed [15:0] w;
		logic has_fixed;   // first result of a solve typed in by hand
		dist_word_t fixed;
	} stim_row_t;

	// predictor state
	edge_t graph_edges[MAX_EDGES];
	int unsigned graph_edge_cnt;
	int unsigned top_vert_reg = 63;
	int unsigned src_vert_reg = 1;
	longint vert_dist[NUM_VERT];
	bit vert_reached[NUM_VERT];

	dist_word_t pending_dists[$];
	int unsigned fail_cnt = 0;
	bit stim_done = 1'b0;

	function automatic bit relax_arc(int unsigned u, int unsigned v, longint w);
		if (!vert_reached[u]) return 1'b0;
		if (vert_reached[v] && vert_dist[v] <= vert_dist[u] + w) return 1'b0;
		vert_dist[v] = vert_dist[u] + w;
		vert_reached[v] = 1'b1;
		return 1'b1;
	endfunction

	function automatic bit arc_open(int unsigned u, int unsigned v, longint w);
		if (!vert_reached[u]) return 1'b0;
		return !vert_reached[v] || vert_dist[v] > vert_dist[u] + w;
	endfunction

	// Work out the words one accepted input word should produce.
	function automatic void predict_paths(logic op, logic [5:0] a, logic [5:0] b,
			logic signed [15:0] w);
		int unsigned vc;
		bit changed;
		bit cyc;
		longint d;
		dist_word_t r;
		if (op == OP_LOAD) begin
			if (graph_edge_cnt < MAX_EDGES) begin
				graph_edges[graph_edge_cnt] = '{a: a, b: b, w: w};
				graph_edge_cnt++;
			end
			return;
		end
		vc = (top_vert_reg == 0) ? 1 : top_vert_reg;
		for (int v = 0; v < NUM_VERT; v++) begin
			vert_dist[v] = 0;
			vert_reached[v] = 1'b0;
		end
		if (src_vert_reg <= vc) vert_reached[src_vert_reg] = 1'b1;
		for (int p = 0; p < vc; p++) begin
			changed = 1'b0;
			for (int i = 0; i < graph_edge_cnt; i++) begin
				if (graph_edges[i].a > vc || graph_edges[i].b > vc) continue;
				if (relax_arc(graph_edges[i].a, graph_edges[i].b, graph_edges[i].w))
					changed = 1'b1;
				if (relax_arc(graph_edges[i].b, graph_edges[i].a, graph_edges[i].w))
					changed = 1'b1;
			end
			if (!changed) break;
		end
		cyc = 1'b0;
		for (int i = 0; i < graph_edge_cnt && !cyc; i++) begin
			if (graph_edges[i].a > vc || graph_edges[i].b > vc) continue;
			if (arc_open(graph_edges[i].a, graph_edges[i].b, graph_edges[i].w) ||
					arc_open(graph_edges[i].b, graph_edges[i].a, graph_edges[i].w))
				cyc = 1'b1;
		end
		graph_edge_cnt = 0;
		if (cyc) begin
			r = '{vnum: '0, pdist: '0, ncyc: 1'b1, last: 1'b1};
			pending_dists.insert(pending_dists.size(), r);
			return;
		end
		for (int v = 1; v <= vc; v++) begin
			d = -1;
			if (vert_reached[v]) begin
				d = vert_dist[v];
				if (d > 4194303) d = 4194303;
				if (d < -4194304) d = -4194304;
			end
			r.vnum = v[5:0];
			r.pdist = d[22:0];
			r.ncyc = 1'b0;
			r.last = (v == vc);
			pending_dists.insert(pending_dists.size(), r);
		end
	endfunction

	// Accept one word; wait a random gap first, hold the payload while stalled.
	task automatic send_word(logic op, logic [5:0] a, logic [5:0] b, logic signed [15:0] w);
		int gap;
		gap = $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		edge_from <= a;
		edge_to <= b;
		edge_weight <= w;
		do @(posedge clk); while (in_stall);
		predict_paths(op, a, b, w);
	endtask

	// Drain outstanding words, then let the block settle before a register write.
	task automatic write_reg(logic idx, logic [5:0] val);
		in_valid <= 1'b0;
		while (pending_dists.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_VCOUNT) top_vert_reg = val;
		else src_vert_reg = val;
	endtask

	// Check each accepted result word against the oldest expectation.
	always @(posedge clk) begin
		dist_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_dists.size() == 0) begin
				$error("unexpected word: vertex %0d distance %0d", vertex_number, path_distance);
				fail_cnt++;
			end else begin
				want = pending_dists.pop_front();
				if (vertex_number !== want.vnum) begin
					$error("vertex_number: expected %0d, got %0d", want.vnum, vertex_number);
					fail_cnt++;
				end
				if (path_distance !== want.pdist) begin
					$error("path_distance: expected %0d, got %0d", want.pdist, path_distance);
					fail_cnt++;
				end
				if (negative_cycle !== want.ncyc) begin
					$error("negative_cycle: expected %0b, got %0b", want.ncyc, negative_cycle);
					fail_cnt++;
				end
				if (last_result !== want.last) begin
					$error("last_result: expected %0b, got %0b", want.last, last_result);
					fail_cnt++;
				end
			end
		end
	end

	// Receiver back-pressure: hold out_stall for a random gap before taking each word.
	initial begin
		int gap;
		forever begin
			gap = $urandom_range(0, 8);
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Directed rows; a solve row may carry its first word typed in by hand.
	localparam dist_word_t NO_WORD = '{vnum: '0, pdist: '0, ncyc: 1'b0, last: 1'b0};
	localparam dist_word_t CYCLE_WORD = '{vnum: '0, pdist: '0, ncyc: 1'b1, last: 1'b1};
	stim_row_t directed_rows[$];

	initial begin
		stim_row_t row;
		int ne;
		int vc;
		logic signed [15:0] w;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty graph after reset: vertex 1 is the source, distance 0
		directed_rows.insert(directed_rows.size(), '{OP_SOLVE, 0, 0, 0, 1'b1,
			'{vnum: 1, pdist: 0, ncyc: 1'b0, last: 1'b0}});
		directed_rows.insert(directed_rows.size(), '{OP_LOAD, 1, 2, 16'sh7fff, 1'b0, NO_WORD});
		directed_rows.insert(directed_rows.size(), '{OP_LOAD, 2, 63, 16'sh7fff, 1'b0, NO_WORD});
		directed_rows.insert(directed_rows.size(), '{OP_LOAD, 63, 0, 16'sh7fff, 1'b0, NO_WORD});
		directed_rows.insert(directed_rows.size(), '{OP_LOAD, 3, 3, 0, 1'b0, NO_WORD});
		directed_rows.insert(directed_rows.size(), '{OP_SOLVE, 0, 0, 0, 1'b0, NO_WORD});
		// any reachable negative edge is a cycle
		directed_rows.insert(directed_rows.size(), '{OP_LOAD, 1, 5, -16'sh8000, 1'b0, NO_WORD});
		directed_rows.insert(directed_rows.size(), '{OP_SOLVE, 0, 0, 0, 1'b1, CYCLE_WORD});
		// negative edge out of reach: plain distances
		directed_rows.insert(directed_rows.size(), '{OP_LOAD, 10, 11, -1, 1'b0, NO_WORD});
		directed_rows.insert(directed_rows.size(), '{OP_LOAD, 1, 4, 16'sh0155, 1'b0, NO_WORD});
		directed_rows.insert(directed_rows.size(), '{OP_LOAD, 4, 6, 16'sh2aaa, 1'b0, NO_WORD});
		directed_rows.insert(directed_rows.size(), '{OP_SOLVE, 0, 0, 0, 1'b0, NO_WORD});
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_word(row.op, row.a, row.b, row.w);
			// earlier words have all drained, so this solve's first word heads the queue
			if (row.has_fixed) pending_dists[0] = row.fixed;
		end

		// long chain of maximum weights: the largest distance a path can reach
		write_reg(CFG_VCOUNT, 63);
		for (int v = 1; v < 63; v++) send_word(OP_LOAD, v[5:0], 6'(v + 1), 16'sh7fff);
		send_word(OP_SOLVE, 0, 0, 0);
		// smallest graph, source 0, source above the top vertex
		write_reg(CFG_VCOUNT, 0);
		write_reg(CFG_SOURCE, 0);
		send_word(OP_LOAD, 0, 1, 7);
		send_word(OP_SOLVE, 0, 0, 0);
		write_reg(CFG_SOURCE, 63);
		write_reg(CFG_VCOUNT, 5);
		send_word(OP_LOAD, 1, 2, 3);
		send_word(OP_SOLVE, 0, 0, 0);

		// random graphs: small sizes mostly, a few extremes
		for (int s = 0; s < 45; s++) begin
			vc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 12);
			write_reg(CFG_VCOUNT, vc[5:0]);
			write_reg(CFG_SOURCE, ($urandom_range(0, 7) == 0) ? 6'($urandom) :
				6'($urandom_range(0, vc)));
			ne = $urandom_range(0, 14);
			for (int i = 0; i < ne; i++) begin
				case ($urandom_range(0, 9))
					0: w = 16'($urandom);
					1: w = -16'($urandom_range(1, 4));
					default: w = 16'($urandom_range(0, 3000));
				endcase
				send_word(OP_LOAD,
					($urandom_range(0, 15) == 0) ? 6'($urandom) : 6'($urandom_range(0, vc)),
					($urandom_range(0, 15) == 0) ? 6'($urandom) : 6'($urandom_range(0, vc)), w);
			end
			send_word(OP_SOLVE, 6'($urandom), 6'($urandom), 16'($urandom));
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		while (pending_dists.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("status: fail");
		$finish;
	end
endmodule
